@@ rtl/mots_pkg.sv @@
// Shared types and constants for the median of two sorted sequences block.
package mots_pkg;

    localparam int SEQ_DEPTH = 256;
    localparam int ADDR_W    = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
    localparam int CNT_W     = $clog2(SEQ_DEPTH + 1);
    localparam int TOT_W     = CNT_W + 1;
    localparam int DATA_W    = 32;

    localparam logic [1:0] KIND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_SECOND = 2'd1;
    localparam logic [1:0] KIND_MEDIAN = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_EMPTY   = 2'd1;
    localparam logic [1:0] STAT_DROPPED = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] median;
        logic [1:0]               status;
    } t_out;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] first_count;
        logic [CNT_W-1:0] second_count;
    } t_walk_ctl;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] median;
    } t_walk_sts;

endpackage

@@ rtl/median_of_two_sorted_sequences.sv @@
// Top level: load control, the two element stores, merge walker and result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready, payload i_in) carries requests.
//   A first or second request appends value to that sequence; when the
//   sequence already holds SEQ_DEPTH elements the value is dropped and the
//   next median request reports STAT_DROPPED. A median request walks both
//   stores like a merge up to the middle, returns one result on the output
//   channel (o_out_valid / i_out_ready, payload o_out) and empties both
//   sequences. Requests of kind three are taken and ignored.
//   Loads are accepted back to back, also while a result waits in the
//   output register. A median request occupies the block until its result
//   is in the output register, the walk stepping the merge against the
//   registered read port of each store; an error result skips the walk.
//   o_in_ready stays low for that time.
//   If the receiver stalls, the result holds in the output register; a
//   further median request then waits before returning to idle.
//   Synchronous active-low reset empties both sequences, clears the drop
//   flag and the output valid flag; store contents stay undefined.
module median_of_two_sorted_sequences (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mots_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output mots_pkg::t_out  o_out
);
    import mots_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]               r_state;
    logic [1:0]               n_state;
    logic [CNT_W-1:0]         r_first_count;
    logic [CNT_W-1:0]         r_second_count;
    logic                     r_dropped;
    logic [1:0]               r_status;
    logic signed [DATA_W-1:0] r_median;
    logic                     r_out_valid;
    t_out                     r_out;

    logic                     in_acc;
    logic                     first_we;
    logic                     second_we;
    logic                     first_full;
    logic                     second_full;
    logic                     is_empty;
    logic                     out_free;
    logic [ADDR_W-1:0]        first_raddr;
    logic [ADDR_W-1:0]        second_raddr;
    logic [DATA_W-1:0]        first_rdata;
    logic [DATA_W-1:0]        second_rdata;
    t_walk_ctl                walk_ctl;
    t_walk_sts                walk_sts;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign first_full  = (r_first_count >= CNT_W'(SEQ_DEPTH));
    assign second_full = (r_second_count >= CNT_W'(SEQ_DEPTH));
    assign first_we    = in_acc && (i_in.kind == KIND_FIRST) && !first_full;
    assign second_we   = in_acc && (i_in.kind == KIND_SECOND) && !second_full;
    assign is_empty    = (r_first_count == '0) && (r_second_count == '0);
    assign out_free    = !r_out_valid || i_out_ready;

    assign walk_ctl.start        = in_acc && (i_in.kind == KIND_MEDIAN)
                                   && !r_dropped && !is_empty;
    assign walk_ctl.first_count  = r_first_count;
    assign walk_ctl.second_count = r_second_count;

    mots_ram #(.WIDTH(DATA_W), .DEPTH(SEQ_DEPTH)) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (first_we),
        .i_waddr (r_first_count[ADDR_W-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (first_raddr),
        .o_rdata (first_rdata)
    );

    mots_ram #(.WIDTH(DATA_W), .DEPTH(SEQ_DEPTH)) u_second_ram (
        .i_clk   (i_clk),
        .i_we    (second_we),
        .i_waddr (r_second_count[ADDR_W-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (second_raddr),
        .o_rdata (second_rdata)
    );

    mots_walk u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (walk_ctl),
        .i_first_data  (first_rdata),
        .i_second_data (second_rdata),
        .o_first_addr  (first_raddr),
        .o_second_addr (second_raddr),
        .o_sts         (walk_sts)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.kind == KIND_MEDIAN)) begin
                    n_state = walk_ctl.start ? S_WALK : S_FINISH;
                end
            end
            S_WALK: begin
                if (walk_sts.done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_first_count  <= '0;
            r_second_count <= '0;
            r_dropped      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (first_we) begin
                r_first_count <= r_first_count + 1'b1;
            end
            if (second_we) begin
                r_second_count <= r_second_count + 1'b1;
            end
            if (in_acc && (((i_in.kind == KIND_FIRST) && first_full)
                    || ((i_in.kind == KIND_SECOND) && second_full))) begin
                r_dropped <= 1'b1;
            end
            if ((r_state == S_FINISH) && out_free) begin
                r_first_count  <= '0;
                r_second_count <= '0;
                r_dropped      <= 1'b0;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in.kind == KIND_MEDIAN)) begin
            r_median <= '0;
            if (r_dropped) begin
                r_status <= STAT_DROPPED;
            end else if (is_empty) begin
                r_status <= STAT_EMPTY;
            end else begin
                r_status <= STAT_OK;
            end
        end else if ((r_state == S_WALK) && walk_sts.done) begin
            r_median <= walk_sts.median;
        end
        if ((r_state == S_FINISH) && out_free) begin
            r_out.median <= r_median;
            r_out.status <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ rtl/mots_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module mots_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mots_walk.sv @@
// Merge walker: steps through both stores one element per cycle up to the middle.
module mots_walk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mots_pkg::t_walk_ctl             i_ctl,
    input  logic [mots_pkg::DATA_W-1:0]     i_first_data,
    input  logic [mots_pkg::DATA_W-1:0]     i_second_data,
    output logic [mots_pkg::ADDR_W-1:0]     o_first_addr,
    output logic [mots_pkg::ADDR_W-1:0]     o_second_addr,
    output mots_pkg::t_walk_sts             o_sts
);
    import mots_pkg::*;

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_W-1:0]         r_i;
    logic [CNT_W-1:0]         r_j;
    logic [CNT_W-1:0]         r_k;
    logic signed [DATA_W-1:0] r_prev;
    logic signed [DATA_W-1:0] r_cur;

    logic [CNT_W-1:0]         n_i;
    logic [CNT_W-1:0]         n_j;
    logic [TOT_W-1:0]         total;
    logic [CNT_W-1:0]         half;
    logic                     take_first;
    logic                     take_second;
    logic signed [DATA_W:0]   sum;
    logic signed [DATA_W:0]   sum_adj;

    assign total = {1'b0, i_ctl.first_count} + {1'b0, i_ctl.second_count};
    assign half  = total[TOT_W-1:1];

    always_comb begin
        priority if (r_i >= i_ctl.first_count) begin
            take_first = 1'b0;
        end else if (r_j >= i_ctl.second_count) begin
            take_first = 1'b1;
        end else begin
            take_first = ($signed(i_first_data) <= $signed(i_second_data));
        end
        take_second = !take_first && (r_j < i_ctl.second_count);
    end

    always_comb begin
        n_i = r_i;
        n_j = r_j;
        if (!r_busy) begin
            n_i = '0;
            n_j = '0;
        end else if (take_first) begin
            n_i = r_i + 1'b1;
        end else if (take_second) begin
            n_j = r_j + 1'b1;
        end
    end

    assign o_first_addr  = n_i[ADDR_W-1:0];
    assign o_second_addr = n_j[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_k == half)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_j <= n_j;
        if (i_ctl.start) begin
            r_k <= '0;
        end else if (r_busy) begin
            r_k    <= r_k + 1'b1;
            r_prev <= r_cur;
            if (take_first) begin
                r_cur <= $signed(i_first_data);
            end else if (take_second) begin
                r_cur <= $signed(i_second_data);
            end
        end
    end

    assign sum     = {r_cur[DATA_W-1], r_cur} + {r_prev[DATA_W-1], r_prev};
    assign sum_adj = sum + {{DATA_W{1'b0}}, sum[DATA_W]};

    assign o_sts.done   = r_done;
    assign o_sts.median = total[0] ? r_cur : sum_adj[DATA_W:1];

endmodule

@@ rtl/mots_chk.sv @@
// Port-level checker for the median block, bound to the top level.
module mots_chk (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            o_in_ready,
    input  mots_pkg::t_in   i_in,
    input  logic            o_out_valid,
    input  logic            i_out_ready,
    input  mots_pkg::t_out  o_out
);
    import mots_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != STAT_OK) |-> (o_out.median == '0))
        else $error("error result carries non-zero median");

    a_median_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in.kind == KIND_MEDIAN) |=> !o_in_ready)
        else $error("request taken during median computation");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result presented straight after reset");

endmodule

bind median_of_two_sorted_sequences mots_chk u_mots_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
